// ===== rtl/reverb_loop_lowpass_chain_macros.svh =====
// assertion macros for the reverb loop lowpass chain
// no dependencies; taken in by the rtl files that carry checks
`ifndef REVERB_LOOP_LOWPASS_CHAIN_MACROS_SVH
`define REVERB_LOOP_LOWPASS_CHAIN_MACROS_SVH
`ifndef SYNTHESIS
`define RLLC_ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("rllc: same-cycle check failed");
`define RLLC_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("rllc: next-cycle check failed");
`define RLLC_ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("rllc: forbidden condition seen");
`else
`define RLLC_ASSERT_IMP(label, clk, rstn, pre, post)
`define RLLC_ASSERT_NEXT(label, clk, rstn, pre, post)
`define RLLC_ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

// ===== rtl/rllc_pkg.sv =====
// shared types and constants of the reverb loop lowpass chain
// no dependencies
package rllc_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 24;
    localparam int POLE_W     = 23;
    localparam int MODE_W     = 4;
    localparam int CHAN_W     = 4;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    // unity in q22
    localparam logic [POLE_W-1:0] ONE_Q22 = 23'd4194304;

    // filter_mode bits
    localparam int MODE_AIR    = 0;
    localparam int MODE_BIQUAD = 1;
    localparam int MODE_FOURTH = 2;
    localparam int MODE_FREEZE = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_B0     = 3'd0,
        REG_COEF_B1     = 3'd1,
        REG_COEF_B2     = 3'd2,
        REG_COEF_A1     = 3'd3,
        REG_COEF_A2     = 3'd4,
        REG_AIR_POLE    = 3'd5,
        REG_FILTER_MODE = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic        [CHAN_W-1:0]   channel;
        logic signed [SAMPLE_W-1:0] damped_sample;
        logic signed [SAMPLE_W-1:0] dry_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] loop_sample;
        logic        [CHAN_W-1:0]   out_channel;
    } out_item_t;

endpackage

// ===== rtl/reverb_loop_lowpass_chain.sv =====
// top level of the reverb loop lowpass chain: one-pole and biquad cascade per channel
// depends on rllc_pkg and reverb_loop_lowpass_chain_macros.svh
//
//   port group   direction  handshake           payload
//   s_*          in         s_valid / s_ready   in_item_t  (channel, damped, dry)
//   m_*          out        m_valid / m_ready   out_item_t (loop sample, channel)
//   cfg_*        in         cfg_we              cfg_index, cfg_wdata
//
// one transaction per cycle for differing channels while m_ready does not stall; a result
// passes stage registers 1 to 9, then the output register; per-channel state sits in one
// memory read at accept, written back from stage 9 unless freeze is set; a transaction
// whose channel is still in flight waits at s_ready until the earlier one leaves stage 9
// reset clears the valid bits of the state memory at once; no clearing pass
// a stalled m_ready holds the output register, and bubbles in the pipe still fill up
`include "reverb_loop_lowpass_chain_macros.svh"

module reverb_loop_lowpass_chain
    import rllc_pkg::*;
#(
    parameter int CHANNELS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,

    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int IDX_W = $clog2(CHANNELS);
    localparam int NSTG  = 9;
    localparam int PROD_W = 48;
    localparam int ACC_W  = 56;
    localparam int STATE_W = 32;
    localparam logic signed [ACC_W-1:0] RND_HALF = 56'sd2097152;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] air;
        logic signed [STATE_W-1:0]  z1a;
        logic signed [STATE_W-1:0]  z2a;
        logic signed [STATE_W-1:0]  z1b;
        logic signed [STATE_W-1:0]  z2b;
    } state_t;

    typedef struct packed {
        logic        [CHAN_W-1:0]   chan;
        logic        [IDX_W-1:0]    idx;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] dry;
        logic                       av;
        logic                       fv;
        logic                       sv;
        state_t                     st;
        logic signed [PROD_W-1:0]   px;
        logic signed [PROD_W-1:0]   pa;
        logic signed [PROD_W-1:0]   b0u;
        logic signed [PROD_W-1:0]   b1u;
        logic signed [PROD_W-1:0]   b2u;
        logic signed [PROD_W-1:0]   a1y;
        logic signed [PROD_W-1:0]   a2y;
        logic signed [PROD_W-1:0]   b0y;
        logic signed [PROD_W-1:0]   b1y;
        logic signed [PROD_W-1:0]   b2y;
        logic signed [PROD_W-1:0]   a1y2;
        logic signed [PROD_W-1:0]   a2y2;
        logic signed [SAMPLE_W-1:0] u1;
        logic signed [SAMPLE_W-1:0] y1;
        logic signed [SAMPLE_W-1:0] y2;
        logic signed [SAMPLE_W-1:0] f;
    } work_t;

    function automatic logic [IDX_W-1:0] chan_to_idx(input logic [CHAN_W-1:0] c);
        int v;
        v = int'(c);
        for (int i = 0; i < 8; i++) begin
            if (v >= CHANNELS) begin
                v = v - CHANNELS;
            end
        end
        return IDX_W'(v);
    endfunction

    function automatic logic signed [ACC_W-1:0] rnd_q22(input logic signed [ACC_W-1:0] v);
        return (v + RND_HALF) >>> 22;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 56'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -56'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [STATE_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [STATE_W-1:0] r;
        if (v > 56'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -56'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[STATE_W-1:0];
        end
        return r;
    endfunction

    // configuration
    logic signed [COEF_W-1:0] coef_b0_reg, coef_b1_reg, coef_b2_reg;
    logic signed [COEF_W-1:0] coef_a1_reg, coef_a2_reg;
    logic        [POLE_W-1:0] air_pole_reg;
    logic        [MODE_W-1:0] filter_mode_reg;
    logic                     freeze_wr;
    logic                     fourth_off_wr;

    // state memory and its valid bits
    state_t                state_mem [CHANNELS];
    state_t                state_rd_reg;
    logic [CHANNELS-1:0]   air_vld_reg;
    logic [CHANNELS-1:0]   fir_vld_reg;
    logic [CHANNELS-1:0]   sec_vld_reg;

    work_t                 pipe_reg  [1:NSTG];
    work_t                 pipe_next [1:NSTG];
    logic [NSTG:1]         stage_vld_reg;
    logic [NSTG:1]         stage_en;
    logic                  out_en;
    logic                  m_valid_reg;
    out_item_t             m_item_reg;
    out_item_t             out_next;

    logic [IDX_W-1:0]      in_idx;
    logic                  hazard;
    logic                  s_fire;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;

    logic [POLE_W-1:0]         p_eff;
    logic signed [SAMPLE_W-1:0] p_s;
    logic signed [SAMPLE_W-1:0] one_m_p_s;

    assign in_idx = chan_to_idx(s_item.channel);
    assign p_eff  = (air_pole_reg > ONE_Q22) ? ONE_Q22 : air_pole_reg;
    assign p_s       = {1'b0, p_eff};
    assign one_m_p_s = {1'b0, ONE_Q22 - p_eff};

    assign freeze_wr     = cfg_we && (cfg_index == 3'(REG_FILTER_MODE))
                           && cfg_wdata[MODE_FREEZE];
    assign fourth_off_wr = cfg_we && (cfg_index == 3'(REG_FILTER_MODE))
                           && !cfg_wdata[MODE_FOURTH];

    // ready chain, output register last
    always_comb begin
        out_en = !m_valid_reg || m_ready;
        stage_en[NSTG] = !stage_vld_reg[NSTG] || out_en;
        for (int k = NSTG - 1; k >= 1; k--) begin
            stage_en[k] = !stage_vld_reg[k] || stage_en[k+1];
        end
    end

    // hold a transaction whose channel has not been written back yet
    always_comb begin
        hazard = 1'b0;
        for (int k = 1; k <= NSTG; k++) begin
            if (stage_vld_reg[k] && (pipe_reg[k].idx == in_idx)) begin
                hazard = 1'b1;
            end
        end
    end

    assign s_ready = stage_en[1] && !hazard;
    assign s_fire  = s_valid && s_ready;

    assign wr_en  = stage_vld_reg[NSTG] && out_en && !filter_mode_reg[MODE_FREEZE];
    assign wr_idx = pipe_reg[NSTG].idx;

    always_comb begin
        logic signed [ACC_W-1:0] t1, t2, t3;
        state_t st;

        // stage 1: capture, memory read in flight
        pipe_next[1]     = '0;
        pipe_next[1].chan = s_item.channel;
        pipe_next[1].idx  = in_idx;
        pipe_next[1].x    = s_item.damped_sample;
        pipe_next[1].dry  = s_item.dry_sample;
        pipe_next[1].av   = air_vld_reg[in_idx];
        pipe_next[1].fv   = fir_vld_reg[in_idx];
        pipe_next[1].sv   = sec_vld_reg[in_idx];

        // stage 2: mask unwritten state, one-pole products
        st = state_rd_reg;
        if (!pipe_reg[1].av) begin
            st.air = '0;
        end
        if (!pipe_reg[1].fv) begin
            st.z1a = '0;
            st.z2a = '0;
        end
        if (!pipe_reg[1].sv) begin
            st.z1b = '0;
            st.z2b = '0;
        end
        pipe_next[2]    = pipe_reg[1];
        pipe_next[2].st = st;
        pipe_next[2].px = PROD_W'(one_m_p_s) * PROD_W'(pipe_reg[1].x);
        pipe_next[2].pa = PROD_W'(p_s) * PROD_W'(st.air);

        // stage 3: one-pole sum, or the input passed on when the air mode is off
        pipe_next[3] = pipe_reg[2];
        t1 = ACC_W'(pipe_reg[2].px);
        t2 = ACC_W'(pipe_reg[2].pa);
        if (filter_mode_reg[MODE_AIR]) begin
            pipe_next[3].st.air = sat24(rnd_q22(t1 + t2));
            pipe_next[3].u1     = sat24(rnd_q22(t1 + t2));
        end else begin
            pipe_next[3].u1     = pipe_reg[2].x;
        end

        // stage 4: first section feedforward products
        pipe_next[4]     = pipe_reg[3];
        pipe_next[4].b0u = PROD_W'(coef_b0_reg) * PROD_W'(pipe_reg[3].u1);
        pipe_next[4].b1u = PROD_W'(coef_b1_reg) * PROD_W'(pipe_reg[3].u1);
        pipe_next[4].b2u = PROD_W'(coef_b2_reg) * PROD_W'(pipe_reg[3].u1);

        // stage 5: first section output
        pipe_next[5] = pipe_reg[4];
        t1 = ACC_W'(pipe_reg[4].b0u);
        t3 = ACC_W'(pipe_reg[4].st.z1a);
        pipe_next[5].y1 = sat24(rnd_q22(t1 + (t3 <<< 22)));

        // stage 6: first feedback and second feedforward products
        pipe_next[6]     = pipe_reg[5];
        pipe_next[6].a1y = PROD_W'(coef_a1_reg) * PROD_W'(pipe_reg[5].y1);
        pipe_next[6].a2y = PROD_W'(coef_a2_reg) * PROD_W'(pipe_reg[5].y1);
        pipe_next[6].b0y = PROD_W'(coef_b0_reg) * PROD_W'(pipe_reg[5].y1);
        pipe_next[6].b1y = PROD_W'(coef_b1_reg) * PROD_W'(pipe_reg[5].y1);
        pipe_next[6].b2y = PROD_W'(coef_b2_reg) * PROD_W'(pipe_reg[5].y1);

        // stage 7: first section state update, second section output
        pipe_next[7] = pipe_reg[6];
        if (filter_mode_reg[MODE_BIQUAD]) begin
            t1 = ACC_W'(pipe_reg[6].b1u);
            t2 = ACC_W'(pipe_reg[6].a1y);
            t3 = ACC_W'(pipe_reg[6].st.z2a);
            pipe_next[7].st.z1a = sat32(rnd_q22(t1 - t2 + (t3 <<< 22)));
            t1 = ACC_W'(pipe_reg[6].b2u);
            t2 = ACC_W'(pipe_reg[6].a2y);
            pipe_next[7].st.z2a = sat32(rnd_q22(t1 - t2));
        end
        t1 = ACC_W'(pipe_reg[6].b0y);
        t3 = ACC_W'(pipe_reg[6].st.z1b);
        pipe_next[7].y2 = sat24(rnd_q22(t1 + (t3 <<< 22)));

        // stage 8: second feedback products
        pipe_next[8]      = pipe_reg[7];
        pipe_next[8].a1y2 = PROD_W'(coef_a1_reg) * PROD_W'(pipe_reg[7].y2);
        pipe_next[8].a2y2 = PROD_W'(coef_a2_reg) * PROD_W'(pipe_reg[7].y2);

        // stage 9: second section state update, filter output select
        pipe_next[9] = pipe_reg[8];
        if (filter_mode_reg[MODE_BIQUAD] && filter_mode_reg[MODE_FOURTH]) begin
            t1 = ACC_W'(pipe_reg[8].b1y);
            t2 = ACC_W'(pipe_reg[8].a1y2);
            t3 = ACC_W'(pipe_reg[8].st.z2b);
            pipe_next[9].st.z1b = sat32(rnd_q22(t1 - t2 + (t3 <<< 22)));
            t1 = ACC_W'(pipe_reg[8].b2y);
            t2 = ACC_W'(pipe_reg[8].a2y2);
            pipe_next[9].st.z2b = sat32(rnd_q22(t1 - t2));
        end
        if (filter_mode_reg[MODE_FREEZE]) begin
            pipe_next[9].f = pipe_reg[8].x;
        end else if (!filter_mode_reg[MODE_BIQUAD]) begin
            pipe_next[9].f = pipe_reg[8].u1;
        end else if (filter_mode_reg[MODE_FOURTH]) begin
            pipe_next[9].f = pipe_reg[8].y2;
        end else begin
            pipe_next[9].f = pipe_reg[8].y1;
        end
    end

    // output: add quarter dry, polarity by channel parity, dry muted on freeze
    always_comb begin
        logic signed [ACC_W-1:0] fa, fd;
        fa = ACC_W'(pipe_reg[NSTG].f);
        fd = ACC_W'(pipe_reg[NSTG].dry);
        if (filter_mode_reg[MODE_FREEZE]) begin
            fd = '0;
        end else if (pipe_reg[NSTG].chan[0]) begin
            fd = -fd;
        end
        fa = (fa <<< 2) + fd + 56'sd2;
        out_next.loop_sample = sat24(fa >>> 2);
        out_next.out_channel = pipe_reg[NSTG].chan;
    end

    // control and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_vld_reg   <= '0;
            m_valid_reg     <= 1'b0;
            air_vld_reg     <= '0;
            fir_vld_reg     <= '0;
            sec_vld_reg     <= '0;
            coef_b0_reg     <= 24'sd4194304;
            coef_b1_reg     <= '0;
            coef_b2_reg     <= '0;
            coef_a1_reg     <= '0;
            coef_a2_reg     <= '0;
            air_pole_reg    <= '0;
            filter_mode_reg <= '0;
        end else begin
            if (stage_en[1]) begin
                stage_vld_reg[1] <= s_fire;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (stage_en[k]) begin
                    stage_vld_reg[k] <= stage_vld_reg[k-1];
                end
            end
            if (out_en) begin
                m_valid_reg <= stage_vld_reg[NSTG];
            end
            if (wr_en) begin
                air_vld_reg[wr_idx] <= 1'b1;
                fir_vld_reg[wr_idx] <= 1'b1;
                sec_vld_reg[wr_idx] <= 1'b1;
            end
            if (cfg_we) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_COEF_B0: coef_b0_reg <= cfg_wdata;
                    REG_COEF_B1: coef_b1_reg <= cfg_wdata;
                    REG_COEF_B2: coef_b2_reg <= cfg_wdata;
                    REG_COEF_A1: coef_a1_reg <= cfg_wdata;
                    REG_COEF_A2: coef_a2_reg <= cfg_wdata;
                    REG_AIR_POLE: air_pole_reg <= cfg_wdata[POLE_W-1:0];
                    REG_FILTER_MODE: filter_mode_reg <= cfg_wdata[MODE_W-1:0];
                    default: ;
                endcase
            end
            if (freeze_wr) begin
                air_vld_reg <= '0;
            end
            if (fourth_off_wr) begin
                sec_vld_reg <= '0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        for (int k = 1; k <= NSTG; k++) begin
            if (stage_en[k]) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
        if (stage_en[1]) begin
            state_rd_reg <= state_mem[in_idx];
        end
        if (out_en) begin
            m_item_reg <= out_next;
        end
    end

    // state memory write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            state_mem[wr_idx] <= pipe_reg[NSTG].st;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `RLLC_ASSERT_NEVER(a_no_stale_read, aclk, aresetn, wr_en && s_fire && (wr_idx == in_idx))
    `RLLC_ASSERT_NEXT(a_freeze_clears_air, aclk, aresetn, freeze_wr, air_vld_reg == '0)
    `RLLC_ASSERT_NEXT(a_fourth_off_clears, aclk, aresetn, fourth_off_wr, sec_vld_reg == '0)
    `RLLC_ASSERT_NEXT(a_tail_held, aclk, aresetn, stage_vld_reg[NSTG] && !out_en, stage_vld_reg[NSTG])

endmodule
